// File: hdl/ppi_pkg.sv
// ppi_pkg: shared types and constants for the pixel palette indexer
// no dependencies; imported by ppi_ctrl, ppi_dp and the top level

package ppi_pkg;

    // pixel and result field widths
    localparam int PIX_W   = 8;
    localparam int COLOR_W = 3 * PIX_W;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 2'd1;

    // output register occupancy
    typedef enum logic [0:0] {
        ST_EMPTY,
        ST_FULL
    } ppi_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // take the input beat, update table, load output register
        logic cfg_we;   // write a configuration register
    } ppi_cmd_t;

endpackage

// File: hdl/ppi_ctrl.sv
// ppi_ctrl: handshake controller, tracks whether the output register holds a beat
// depends on ppi_pkg

module ppi_ctrl
    import ppi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     m_tready,
    input  logic     cfg_valid,
    output logic     s_tready,
    output logic     m_tvalid,
    output logic     cfg_ready,
    output ppi_cmd_t cmd
);

    ppi_state_t state_reg;
    ppi_state_t state_next;
    logic       take_in;

    assign take_in = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (take_in)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (take_in)
                begin
                    state_next = ST_FULL;
                end
                else if (m_tready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        case (state_reg)
            ST_EMPTY:
            begin
                s_tready = 1'b1;
            end
            ST_FULL:
            begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        cmd.load = s_tvalid && s_tready;
    end

endmodule

// File: hdl/ppi_dp.sv
// ppi_dp: color table, parallel match, priority encoder and output register
// depends on ppi_pkg; driven by ppi_ctrl commands

module ppi_dp
    import ppi_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppi_cmd_t              cmd,
    input  logic [PIX_W-1:0]      red,
    input  logic [PIX_W-1:0]      green,
    input  logic [PIX_W-1:0]      blue,
    input  logic                  first_pixel,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [INDEX_W-1:0]    pixel_index,
    output logic                  new_color,
    output logic                  overflow,
    output logic [COUNT_W-1:0]    color_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [COLOR_W-1:0] color_table_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]   colors_used_reg;
    logic               shift_enable_reg;
    logic [1:0]         shift_amount_reg;

    logic [INDEX_W-1:0] index_reg;
    logic               new_color_reg;
    logic               overflow_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [COLOR_W-1:0]       color;
    logic [CNT_W-1:0]         used_eff;
    logic [TABLE_DEPTH-1:0]   hit;
    logic                     found;
    logic [IDX_W-1:0]         hit_idx;
    logic                     full;
    logic                     add;
    logic                     ovf;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W+INDEX_W-1:0] idx_ext;
    logic [INDEX_W-1:0]       idx4;
    logic [1:0]               idx_rot;
    logic [INDEX_W-1:0]       index_next;
    logic [CNT_W-1:0]         colors_used_next;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign color    = {red, green, blue};
    assign used_eff = first_pixel ? '0 : colors_used_reg;

    // compare against every live entry
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit[i] = (color_table_reg[i] == color) && (CNT_W'(i) < used_eff);
        end
    end

    // lowest matching entry wins
    always_comb
    begin
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign found = |hit;
    assign full  = (used_eff == CNT_W'(TABLE_DEPTH));
    assign add   = !found && !full;
    assign ovf   = !found && full;
    assign idx   = found ? hit_idx : used_eff[IDX_W-1:0];

    assign colors_used_next = add ? used_eff + 1'b1 : used_eff;

    assign idx_ext = {{INDEX_W{1'b0}}, idx};
    assign idx4    = idx_ext[INDEX_W-1:0];
    assign idx_rot = idx4[1:0] + shift_amount_reg;

    always_comb
    begin
        if (ovf)
        begin
            index_next = '0;
        end
        else if (shift_enable_reg)
        begin
            index_next = {{(INDEX_W-2){1'b0}}, idx_rot};
        end
        else
        begin
            index_next = idx4;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, colors_used_next};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_used_reg  <= '0;
            shift_enable_reg <= 1'b0;
            shift_amount_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                colors_used_reg <= colors_used_next;
            end
            if (cmd.cfg_we)
            begin
                case (cfg_index)
                    CFG_SHIFT_ENABLE: shift_enable_reg <= cfg_data[0];
                    CFG_SHIFT_AMOUNT: shift_amount_reg <= cfg_data[1:0];
                    default:          ;
                endcase
            end
        end
    end

    // table entries and output register, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (add)
            begin
                color_table_reg[used_eff[IDX_W-1:0]] <= color;
            end
            index_reg     <= index_next;
            new_color_reg <= add;
            overflow_reg  <= ovf;
            count_reg     <= count_ext[COUNT_W-1:0];
        end
    end

    assign pixel_index = index_reg;
    assign new_color   = new_color_reg;
    assign overflow    = overflow_reg;
    assign color_count = count_reg;

endmodule

// File: hdl/pixel_palette_indexer.sv
// pixel_palette_indexer: top level, maps rgb pixels to first-seen palette indexes
// depends on ppi_pkg, ppi_ctrl and ppi_dp
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  ------------------------------------------
//  s_*       in   s_tvalid/s_tready    tdata: red, green, blue; tuser: first_pixel
//  m_*       out  m_tvalid/m_tready    tdata: pixel_index, color_count;
//                                      tuser: new_color, overflow
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (0 shift_enable,
//                                      1 shift_amount)
//
// one beat per cycle while the output is not stalled: the match over all
// table entries, the priority encoder and the table append all finish in
// the accepting cycle, and the output register takes the result at its end
// the output register is the only buffer: s_tready follows m_tready while a
// result waits, so a stalled output stalls input without losing a beat
// reset clears the color count and configuration; table contents are only
// read below the count, so they need no clearing
// cfg_ready is always high; write config only while the block is idle

module pixel_palette_indexer
    import ppi_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic                  s_tuser,   // [0] first_pixel
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [3:0] pixel_index, [8:4] color_count, zero pad
    output logic [1:0]            m_tuser,   // [0] new_color, [1] overflow
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ppi_cmd_t           cmd;
    logic [INDEX_W-1:0] pixel_index;
    logic               new_color;
    logic               overflow;
    logic [COUNT_W-1:0] color_count;

    // handshake and command sequencing
    ppi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // color table and result path
    ppi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .red         (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .blue        (s_tdata[23:16]),
        .first_pixel (s_tuser),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_index (pixel_index),
        .new_color   (new_color),
        .overflow    (overflow),
        .color_count (color_count)
    );

    // pack result beat
    assign m_tdata = {7'b0, color_count, pixel_index};
    assign m_tuser = {overflow, new_color};

endmodule

// File: hdl/ppi_checker.sv
// ppi_checker: port-level assertions for pixel_palette_indexer, bound to the top
// depends on the top level's port list only

module ppi_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a waiting result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // every accepted pixel gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted pixel produced no result");

    // a pixel cannot both add a color and overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("new_color and overflow both set");

    // overflow reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[3:0] == 4'd0)
        else $error("overflow with nonzero index");

endmodule

bind pixel_palette_indexer ppi_checker u_ppi_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
